>>> src/uvl_pkg.sv
// Package for the unique value list table.
// Holds table sizes, action and status codes, request/response and control structs.
// No dependencies.
package uvl_pkg;

  localparam int DEPTH  = 16;
  localparam int SLOT_W = 4;
  localparam int CNT_W  = 5;

  typedef enum logic [1:0] {
    ACT_SEARCH = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] item_value;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

endpackage

>>> src/uvl_ctrl.sv
// Controller for the unique value list table.
// Sequences request capture and execution; depends on uvl_pkg.
module uvl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  uvl_pkg::dp_stat_t  stat,
  output uvl_pkg::dp_cmd_t   cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.exec   = 1'b0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!stat.out_busy) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> src/uvl_dp.sv
// Datapath for the unique value list table.
// Holds the register table, count, parallel match and output register; depends on uvl_pkg.
module uvl_dp (
  input  logic               clk,
  input  logic               rst,
  input  uvl_pkg::req_t      in_data,
  input  uvl_pkg::dp_cmd_t   cmd,
  output uvl_pkg::dp_stat_t  stat,
  output logic               out_valid,
  input  logic               out_ready,
  output uvl_pkg::rsp_t      out_data
);

  logic [31:0]                entries [uvl_pkg::DEPTH];
  logic [uvl_pkg::CNT_W-1:0]  used_count;
  logic [uvl_pkg::CNT_W-1:0]  count_next;
  uvl_pkg::req_t              req;
  uvl_pkg::rsp_t              rsp_next;
  logic [uvl_pkg::DEPTH-1:0]  hit;
  logic                       any_hit;
  logic [uvl_pkg::SLOT_W-1:0] hit_idx;
  logic                       do_insert;
  logic                       do_delete;

  always_comb begin
    for (int i = 0; i < uvl_pkg::DEPTH; i++) begin
      hit[i] = (uvl_pkg::CNT_W'(i) < used_count) && (entries[i] == req.item_value);
    end
    any_hit = |hit;
    hit_idx = '0;
    for (int i = uvl_pkg::DEPTH - 1; i >= 0; i--) begin
      if (hit[i]) hit_idx = uvl_pkg::SLOT_W'(i);
    end
  end

  always_comb begin
    rsp_next.status = uvl_pkg::ST_NOT_FOUND;
    rsp_next.slot   = '0;
    count_next      = used_count;
    do_insert       = 1'b0;
    do_delete       = 1'b0;
    case (uvl_pkg::action_t'(req.action))
      uvl_pkg::ACT_SEARCH: begin
        if (any_hit) begin
          rsp_next.status = uvl_pkg::ST_OK;
          rsp_next.slot   = hit_idx;
        end
      end
      uvl_pkg::ACT_INSERT: begin
        if (used_count >= uvl_pkg::CNT_W'(uvl_pkg::DEPTH)) begin
          rsp_next.status = uvl_pkg::ST_FULL;
        end else if (any_hit) begin
          rsp_next.status = uvl_pkg::ST_DUPLICATE;
        end else begin
          rsp_next.status = uvl_pkg::ST_OK;
          rsp_next.slot   = used_count[uvl_pkg::SLOT_W-1:0];
          count_next      = used_count + uvl_pkg::CNT_W'(1);
          do_insert       = 1'b1;
        end
      end
      uvl_pkg::ACT_DELETE: begin
        if (any_hit) begin
          rsp_next.status = uvl_pkg::ST_OK;
          rsp_next.slot   = hit_idx;
          count_next      = used_count - uvl_pkg::CNT_W'(1);
          do_delete       = 1'b1;
        end
      end
      default: ;
    endcase
    rsp_next.entry_count = count_next;
  end

  // hold request, then apply it to the table
  always_ff @(posedge clk) begin
    if (cmd.load) req <= in_data;
    if (cmd.exec) begin
      out_data <= rsp_next;
      if (do_insert) entries[used_count[uvl_pkg::SLOT_W-1:0]] <= req.item_value;
      if (do_delete) begin
        for (int i = 0; i < uvl_pkg::DEPTH - 1; i++) begin
          if (uvl_pkg::SLOT_W'(i) >= hit_idx) entries[i] <= entries[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.exec) begin
        used_count <= count_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign stat.out_busy = out_valid && !out_ready;

endmodule

>>> src/unique_value_list_table.sv
// Unique value list table: search, insert and delete over a compact table of 16 values.
// Each accepted request is captured into a holding register, then executed into the output register once it is free.
// The capture/execute controller loop accepts no new request until the previous one has executed.
// A pending result waits in the output register while the next request is captured.
// Reset: synchronous active-high rst clears the count and the handshake state;
// table contents are not cleared.
module unique_value_list_table (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  uvl_pkg::req_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output uvl_pkg::rsp_t  out_data
);

  uvl_pkg::dp_cmd_t  cmd;
  uvl_pkg::dp_stat_t stat;

  uvl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  uvl_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one still executing");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.entry_count <= uvl_pkg::CNT_W'(uvl_pkg::DEPTH))
    else $error("entry count exceeds table depth");

  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != uvl_pkg::ST_OK |-> out_data.slot == '0)
    else $error("nonzero slot on failed request");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == uvl_pkg::ST_FULL
      |-> out_data.entry_count == uvl_pkg::CNT_W'(uvl_pkg::DEPTH))
    else $error("full status with table not full");

endmodule

>>> dv/tb_unique_value_list_table.sv
`timescale 1ns / 1ps
// Testbench for unique_value_list_table: directed and random search/insert/delete requests,
// checked against an in-bench table model under random stalls on both channels.
// Depends on uvl_pkg and the unique_value_list_table RTL.
module tb_unique_value_list_table;
  import uvl_pkg::*;

  localparam int RAND_REQS   = 400;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 10;
  localparam int POOL_SIZE   = 20;

  logic  clk;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_ready;
  req_t  in_data = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  rsp_t  out_data;

  req_t        table_req_q[$];
  rsp_t        table_rsp_q[$];
  logic [31:0] value_table [DEPTH];
  int          table_used = 0;
  logic        req_fire = 1'b0;
  int          reqs_taken = 0;
  int          total_reqs = 0;
  int          err_cnt = 0;
  int          quiet_cycles = 0;

  unique_value_list_table u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic add_req(action_t act, logic [31:0] value);
    req_t r;
    r.action     = act;
    r.item_value = value;
    table_req_q.push_back(r);
  endtask

  function automatic rsp_t apply_table_op(req_t r);
    rsp_t rsp;
    int   hit;
    hit        = -1;
    rsp.status = ST_NOT_FOUND;
    rsp.slot   = '0;
    for (int i = 0; i < table_used; i++) begin
      if (hit < 0 && value_table[i] == r.item_value) hit = i;
    end
    case (r.action)
      ACT_SEARCH: begin
        if (hit >= 0) begin
          rsp.status = ST_OK;
          rsp.slot   = hit[SLOT_W-1:0];
        end
      end
      ACT_INSERT: begin
        if (table_used >= DEPTH) begin
          rsp.status = ST_FULL;
        end else if (hit >= 0) begin
          rsp.status = ST_DUPLICATE;
        end else begin
          value_table[table_used] = r.item_value;
          rsp.slot   = table_used[SLOT_W-1:0];
          table_used++;
          rsp.status = ST_OK;
        end
      end
      ACT_DELETE: begin
        if (hit >= 0) begin
          for (int i = hit; i < table_used - 1; i++) value_table[i] = value_table[i + 1];
          table_used--;
          rsp.slot   = hit[SLOT_W-1:0];
          rsp.status = ST_OK;
        end
      end
      default: begin
      end
    endcase
    rsp.entry_count = table_used[CNT_W-1:0];
    return rsp;
  endfunction

  // idle mix by stage: sender light / receiver heavy, then swapped, then none
  function automatic int send_idle_pct();
    if (reqs_taken * 3 < total_reqs) return 25;
    if (reqs_taken * 3 < total_reqs * 2) return 68;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (reqs_taken * 3 < total_reqs) return 68;
    if (reqs_taken * 3 < total_reqs * 2) return 25;
    return 0;
  endfunction

  // driver: hold the request until taken, then load the next or idle
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || req_fire) begin
        if (table_req_q.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
          in_valid <= 1'b1;
          in_data  <= table_req_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct());
    end
  end

  // monitor: predict on request accept, check on response accept
  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (rst) begin
      req_fire     <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      req_fire <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        table_rsp_q.push_back(apply_table_op(in_data));
        reqs_taken <= reqs_taken + 1;
      end
      if (out_valid && out_ready) begin
        if (table_rsp_q.size() == 0) begin
          report_mismatch($sformatf("unexpected response status=%0d slot=%0d count=%0d",
                                    out_data.status, out_data.slot, out_data.entry_count));
        end else begin
          exp_rsp = table_rsp_q.pop_front();
          if (out_data.status !== exp_rsp.status)
            report_mismatch($sformatf("status got %0d exp %0d",
                                      out_data.status, exp_rsp.status));
          if (out_data.slot !== exp_rsp.slot)
            report_mismatch($sformatf("slot got %0d exp %0d", out_data.slot, exp_rsp.slot));
          if (out_data.entry_count !== exp_rsp.entry_count)
            report_mismatch($sformatf("entry_count got %0d exp %0d",
                                      out_data.entry_count, exp_rsp.entry_count));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [31:0] value_pool [POOL_SIZE];
    logic [31:0] value;
    int          pick;
    int          insert_pct;
    int          delete_pct;

    // empty table, unused action, extremes, duplicate, delete with shift
    add_req(ACT_SEARCH, 32'd5);
    add_req(ACT_DELETE, 32'd5);
    add_req(ACT_NOP,    32'hFFFF_FFFF);
    add_req(ACT_INSERT, 32'h8000_0000);
    add_req(ACT_INSERT, 32'h7FFF_FFFF);
    add_req(ACT_INSERT, 32'h0000_0000);
    add_req(ACT_INSERT, 32'hFFFF_FFFF);
    add_req(ACT_INSERT, 32'h8000_0000);
    add_req(ACT_SEARCH, 32'h7FFF_FFFF);
    add_req(ACT_DELETE, 32'h7FFF_FFFF);
    add_req(ACT_SEARCH, 32'hFFFF_FFFF);
    // fill to capacity, then full beats duplicate
    for (int i = 1; i <= 13; i++) add_req(ACT_INSERT, 32'h0101_0101 * i);
    add_req(ACT_INSERT, 32'h0000_0000);
    add_req(ACT_INSERT, 32'h1234_5678);
    add_req(ACT_DELETE, 32'h8000_0000);
    add_req(ACT_DELETE, 32'h0D0D_0D0D);

    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;

    // alternate insert-heavy and delete-heavy runs so the count sweeps empty to full
    for (int n = 0; n < RAND_REQS; n++) begin
      insert_pct = ((n / 40) % 2 == 0) ? 60 : 20;
      delete_pct = ((n / 40) % 2 == 0) ? 20 : 60;
      value = ($urandom_range(99) < 85) ? value_pool[$urandom_range(POOL_SIZE - 1)]
                                        : $urandom;
      pick = $urandom_range(99);
      if (pick < 4)
        add_req(ACT_NOP, value);
      else if (pick < 4 + insert_pct)
        add_req(ACT_INSERT, value);
      else if (pick < 4 + insert_pct + delete_pct)
        add_req(ACT_DELETE, value);
      else
        add_req(ACT_SEARCH, value);
    end
    total_reqs = table_req_q.size();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (table_req_q.size() > 0 || in_valid || table_rsp_q.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
